// ===== hw/rtl/subset_sum_reachability_top_macros.svh =====
// ----------------------------------------------------------------------------
// subset sum reachability assertion macros
// shared property wrappers for the checker, clocked on clk, reset on arst_n
// ----------------------------------------------------------------------------
`ifndef SUBSET_SUM_REACHABILITY_TOP_MACROS_SVH
`define SUBSET_SUM_REACHABILITY_TOP_MACROS_SVH

// same-cycle implication
`define SSR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ssr check failed");

// next-cycle implication
`define SSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ssr check failed");

`endif

// ===== hw/rtl/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg
// shared constants, state type and control struct of the subset sum block
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

	localparam int unsigned MAX_SUM_DEF   = 1023;
	localparam int unsigned WORD_BITS_DEF = 64;
	localparam int unsigned NWORDS_DEF    = (MAX_SUM_DEF + WORD_BITS_DEF) / WORD_BITS_DEF;
	localparam int unsigned VAL_W         = 16;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_POST
	} state_t;

	// per-cycle controls from the sequencer to the word merge datapath
	typedef struct packed {
		logic hit_clr;
		logic iss;
		logic dv;
		logic b_ok;
		logic fixed_wr;
		logic skip;
	} merge_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssr_ram.sv =====
// ----------------------------------------------------------------------------
// ssr_ram
// generic memory, one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_ram #(
	parameter int unsigned WIDTH = ssr_pkg::WORD_BITS_DEF,
	parameter int unsigned DEPTH = ssr_pkg::NWORDS_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ssr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssr_ctrl
// sequencer: handshakes, word sweep addresses, shift split, result register
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_ctrl #(
	parameter int unsigned MAX_SUM   = ssr_pkg::MAX_SUM_DEF,
	parameter int unsigned WORD_BITS = ssr_pkg::WORD_BITS_DEF,
	localparam int unsigned NW = (MAX_SUM + WORD_BITS) / WORD_BITS,
	localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1,
	localparam int unsigned BW = $clog2(WORD_BITS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     elem_valid,
	output logic                     elem_stall,
	input  logic [ssr_pkg::VAL_W-1:0] element_value,
	input  logic [ssr_pkg::VAL_W-1:0] target_sum,
	input  logic                     last_element,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic                     reachable,
	output logic                     target_out_of_range,
	output logic [AW-1:0]            rd_addr_a,
	output logic [AW-1:0]            rd_addr_b,
	output logic                     wr_en,
	output logic [AW-1:0]            wr_addr,
	output logic [BW-1:0]            shift_amt,
	output logic [ssr_pkg::VAL_W-1:0] target,
	output ssr_pkg::merge_ctl_t      ctl,
	input  logic                     hit
);

	localparam int unsigned TW  = $clog2(NW + 1);
	localparam int unsigned CW  = TW + 1;
	localparam int unsigned VW  = ssr_pkg::VAL_W;
	// reciprocal for the word index of an element
	localparam int unsigned RK  = VW + BW;
	localparam int unsigned RM  = ((1 << RK) + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned PW  = VW + RK - BW + 1;

	ssr_pkg::state_t state_q, state_d;

	logic [TW-1:0]  t_q;
	logic [VW-1:0]  v_q;
	logic [VW-1:0]  target_q;
	logic [AW-1:0]  q_q;
	logic [BW-1:0]  r_q;
	logic           last_q;
	logic           skip_q;
	logic           iss_s1;
	logic           dv_s1;
	logic           b_ok_s1;
	logic [AW-1:0]  w_s1;
	logic           res_valid_q;
	logic           reachable_q;
	logic           oor_q;

	logic           accept;
	logic           issue;
	logic           init_wr;
	logic           res_load;
	logic           skip_in;
	logic [PW-1:0]  prod;
	logic [AW-1:0]  q_calc;
	logic [BW-1:0]  r_calc;
	logic [CW-1:0]  a_idx;
	logic [CW-1:0]  b_idx;
	logic           oor_now;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssr_pkg::ST_INIT: begin
				if (t_q == TW'(NW - 1)) state_d = ssr_pkg::ST_IDLE;
			end
			ssr_pkg::ST_IDLE: begin
				if (elem_valid) state_d = ssr_pkg::ST_SCAN;
			end
			ssr_pkg::ST_SCAN: begin
				if (t_q == TW'(NW)) state_d = ssr_pkg::ST_FLUSH;
			end
			ssr_pkg::ST_FLUSH: begin
				state_d = last_q ? ssr_pkg::ST_POST : ssr_pkg::ST_IDLE;
			end
			ssr_pkg::ST_POST: begin
				if (!res_valid_q || !res_stall) state_d = ssr_pkg::ST_IDLE;
			end
			default: state_d = ssr_pkg::ST_INIT;
		endcase
	end

	// state outputs
	always_comb begin
		elem_stall = 1'b1;
		issue      = 1'b0;
		init_wr    = 1'b0;
		res_load   = 1'b0;
		case (state_q)
			ssr_pkg::ST_INIT:  init_wr = 1'b1;
			ssr_pkg::ST_IDLE:  elem_stall = 1'b0;
			ssr_pkg::ST_SCAN:  issue = 1'b1;
			ssr_pkg::ST_FLUSH: ;
			ssr_pkg::ST_POST:  res_load = !res_valid_q || !res_stall;
			default: ;
		endcase
	end

	assign accept  = elem_valid && !elem_stall;
	assign skip_in = (element_value == '0) || (element_value > VW'(MAX_SUM));
	assign prod    = PW'(element_value) * PW'(RM);
	assign q_calc  = AW'(prod >> RK);
	assign r_calc  = BW'(v_q - VW'(q_q) * VW'(WORD_BITS));

	// word t reads: own word high to low, source word one below the shifted one
	assign a_idx = CW'(NW) - CW'(t_q);
	assign b_idx = CW'(NW - 1) - CW'(q_q) - CW'(t_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssr_pkg::ST_INIT;
			t_q     <= '0;
			last_q  <= 1'b0;
			iss_s1  <= 1'b0;
			dv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			iss_s1  <= issue;
			dv_s1   <= issue && (t_q != '0);
			if (accept) begin
				t_q    <= '0;
				last_q <= last_element;
			end else if (init_wr) begin
				t_q <= (t_q == TW'(NW - 1)) ? '0 : t_q + 1'b1;
			end else if (issue) begin
				t_q <= t_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q      <= element_value;
			target_q <= target_sum;
			skip_q   <= skip_in;
			q_q      <= skip_in ? '0 : q_calc;
		end
		if (issue && (t_q == '0)) begin
			r_q <= r_calc;
		end
		b_ok_s1 <= !b_idx[CW-1];
		w_s1    <= a_idx[AW-1:0];
	end

	// result register
	assign oor_now = target_q > VW'(MAX_SUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			reachable_q <= hit && !oor_now;
			oor_q       <= oor_now;
		end
	end

	assign res_valid           = res_valid_q;
	assign reachable           = reachable_q;
	assign target_out_of_range = oor_q;

	assign rd_addr_a = a_idx[AW-1:0];
	assign rd_addr_b = b_idx[AW-1:0];
	assign wr_en     = init_wr || dv_s1;
	assign wr_addr   = init_wr ? t_q[AW-1:0] : w_s1;
	assign shift_amt = r_q;
	assign target    = target_q;

	assign ctl.hit_clr  = accept;
	assign ctl.iss      = iss_s1;
	assign ctl.dv       = dv_s1;
	assign ctl.b_ok     = b_ok_s1;
	assign ctl.fixed_wr = init_wr || last_q;
	assign ctl.skip     = skip_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ssr_merge.sv =====
// ----------------------------------------------------------------------------
// ssr_merge
// one bitset word per cycle: shifted or, top word trim, target bit capture
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_merge #(
	parameter int unsigned MAX_SUM   = ssr_pkg::MAX_SUM_DEF,
	parameter int unsigned WORD_BITS = ssr_pkg::WORD_BITS_DEF,
	localparam int unsigned NW = (MAX_SUM + WORD_BITS) / WORD_BITS,
	localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1,
	localparam int unsigned BW = $clog2(WORD_BITS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ssr_pkg::merge_ctl_t       ctl,
	input  logic [AW-1:0]             wr_idx,
	input  logic [BW-1:0]             shift_amt,
	input  logic [ssr_pkg::VAL_W-1:0] target,
	input  logic [WORD_BITS-1:0]      rd_a,
	input  logic [WORD_BITS-1:0]      rd_b,
	output logic [WORD_BITS-1:0]      wdata,
	output logic                      hit
);

	localparam int unsigned TOP_BITS = MAX_SUM + 1 - (NW - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] TOP_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - TOP_BITS);
	localparam int unsigned DW = ssr_pkg::VAL_W + 1;

	logic [WORD_BITS-1:0]   upper_q;
	logic [WORD_BITS-1:0]   lower;
	logic [2*WORD_BITS-1:0] cat_sh;
	logic [WORD_BITS-1:0]   merged;
	logic [WORD_BITS-1:0]   new_word;
	logic [DW-1:0]          base;
	logic [DW-1:0]          diff;
	logic                   in_word;
	logic                   hit_q;

	assign lower = ctl.b_ok ? rd_b : '0;

	// source words stream high to low, last one becomes the upper half
	always_ff @(posedge clk) begin
		if (ctl.iss) begin
			upper_q <= lower;
		end
	end

	assign cat_sh   = {upper_q, lower} << shift_amt;
	assign merged   = rd_a | (ctl.skip ? '0 : cat_sh[2*WORD_BITS-1:WORD_BITS]);
	assign new_word = (wr_idx == AW'(NW - 1)) ? (merged & TOP_MASK) : merged;

	// clear pattern keeps only sum zero
	assign wdata = ctl.fixed_wr ? {{(WORD_BITS-1){1'b0}}, (wr_idx == '0)} : new_word;

	assign base    = DW'(wr_idx) * DW'(WORD_BITS);
	assign diff    = {1'b0, target} - base;
	assign in_word = !diff[DW-1] && (diff < DW'(WORD_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.hit_clr) begin
			hit_q <= 1'b0;
		end else if (ctl.dv && in_word) begin
			hit_q <= new_word[diff[BW-1:0]];
		end
	end

	assign hit = hit_q;

endmodule

`default_nettype wire

// ===== hw/rtl/subset_sum_reachability_top.sv =====
// ----------------------------------------------------------------------------
// subset_sum_reachability_top
// bitset subset sum: fold elements, answer reachability of a target sum
// ----------------------------------------------------------------------------
// The block keeps one bit per sum 0..MAX_SUM in a memory of
// (MAX_SUM+WORD_BITS)/WORD_BITS words (16 at the defaults), starting with only
// sum 0 set. Each element transaction ORs the bitset with itself shifted up by
// the element; zero or an element above MAX_SUM leaves it unchanged. The
// bitset is swept one word per cycle from the top word down; from the
// acceptance of an element to the next acceptance the block goes through
// a sweep step per word, a step to prime the source word pipeline, a step
// to write the last word and an idle state that takes the next transaction.
// The element marked last also passes through a result state, in which the
// result (reachable, target_out_of_range) goes to the output register; the
// block waits in that state while an earlier result is still stalled. The
// last element's sweep writes the bitset back to only sum 0. After reset a
// clearing pass fills the memory before the first element is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module subset_sum_reachability_top #(
	parameter int unsigned MAX_SUM   = ssr_pkg::MAX_SUM_DEF,
	parameter int unsigned WORD_BITS = ssr_pkg::WORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// element channel
	input  logic                      elem_valid,
	output logic                      elem_stall,
	input  logic [ssr_pkg::VAL_W-1:0] element_value,
	input  logic [ssr_pkg::VAL_W-1:0] target_sum,
	input  logic                      last_element,
	// result channel
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic                      reachable,
	output logic                      target_out_of_range
);

	localparam int unsigned NW = (MAX_SUM + WORD_BITS) / WORD_BITS;
	localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;
	localparam int unsigned BW = $clog2(WORD_BITS);

	// memory ports
	logic [AW-1:0]            rd_addr_a;
	logic [AW-1:0]            rd_addr_b;
	logic [WORD_BITS-1:0]     rd_data_a;
	logic [WORD_BITS-1:0]     rd_data_b;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [WORD_BITS-1:0]     wr_data;

	// sequencer to datapath
	logic [BW-1:0]             shift_amt;
	logic [ssr_pkg::VAL_W-1:0] target;
	ssr_pkg::merge_ctl_t       ctl;
	logic                      hit;

	// sequencer: handshakes, sweep counter, element split into word and bit
	// offset, result register
	ssr_ctrl #(
		.MAX_SUM   (MAX_SUM),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk                 (clk),
		.arst_n              (arst_n),
		.elem_valid          (elem_valid),
		.elem_stall          (elem_stall),
		.element_value       (element_value),
		.target_sum          (target_sum),
		.last_element        (last_element),
		.res_valid           (res_valid),
		.res_stall           (res_stall),
		.reachable           (reachable),
		.target_out_of_range (target_out_of_range),
		.rd_addr_a           (rd_addr_a),
		.rd_addr_b           (rd_addr_b),
		.wr_en               (wr_en),
		.wr_addr             (wr_addr),
		.shift_amt           (shift_amt),
		.target              (target),
		.ctl                 (ctl),
		.hit                 (hit)
	);

	// word datapath: own word or'ed with the shifted source, target snoop
	ssr_merge #(
		.MAX_SUM   (MAX_SUM),
		.WORD_BITS (WORD_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.wr_idx    (wr_addr),
		.shift_amt (shift_amt),
		.target    (target),
		.rd_a      (rd_data_a),
		.rd_b      (rd_data_b),
		.wdata     (wr_data),
		.hit       (hit)
	);

	// bitset storage; port a reads the word being rewritten, port b the
	// source word, writes during the sweep land above both read addresses
	ssr_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NW)
	) u_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (rd_addr_a),
		.rdata_a (rd_data_a),
		.raddr_b (rd_addr_b),
		.rdata_b (rd_data_b)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ssr_chk.sv =====
// ----------------------------------------------------------------------------
// ssr_chk
// port level checks of the subset sum block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "subset_sum_reachability_top_macros.svh"

module ssr_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic elem_valid,
	input wire logic elem_stall,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire logic reachable,
	input wire logic target_out_of_range
);

	// stalled result holds
	`SSR_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(reachable) && $stable(target_out_of_range))
	// out of range target never reports reachable
	`SSR_ASSERT_NOW(a_oor_excl, res_valid && target_out_of_range, !reachable)
	// an accepted element keeps the block busy for its sweep
	`SSR_ASSERT_NEXT(a_busy, elem_valid && !elem_stall, elem_stall)
	// no result appears right after an element transaction
	`SSR_ASSERT_NEXT(a_no_early, elem_valid && !elem_stall, !$rose(res_valid))

endmodule

bind subset_sum_reachability_top ssr_chk u_chk (.*);

`default_nettype wire
